[rtl/core/utf16_newline_converter_assert.svh]
// assertion macros shared by the utf16 newline converter modules
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef UTF16_NEWLINE_CONVERTER_ASSERT_SVH
`define UTF16_NEWLINE_CONVERTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// condition implies consequence in the same cycle
`define UNC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utf16 newline converter check failed");
// condition implies consequence in the next cycle
`define UNC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utf16 newline converter check failed");
`else
`define UNC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define UNC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/unc_pkg.sv]
// types and constants for the utf16 newline converter
// no dependencies; used by every module of the block
package unc_pkg;

    // line ending formats
    localparam logic [1:0] FMT_LF   = 2'd0;
    localparam logic [1:0] FMT_CR   = 2'd1;
    localparam logic [1:0] FMT_CRLF = 2'd2;

    // register indexes on the configuration port
    localparam logic [1:0] REG_SOURCE = 2'd0;
    localparam logic [1:0] REG_TARGET = 2'd1;
    localparam logic [1:0] REG_SWAP   = 2'd2;

    localparam logic [7:0] CODE_CR  = 8'h0D;
    localparam logic [7:0] CODE_LF  = 8'h0A;
    localparam logic [7:0] BOM_HIGH = 8'hFE;
    localparam logic [7:0] BOM_LOW  = 8'hFF;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0] source_format;
        logic [1:0] target_format;
        logic       swap_bytes;
    } unc_cfg_t;

    typedef struct packed {
        logic [7:0] second_byte;
        logic [7:0] first_byte;
    } unc_unit_t;

    // one classified input: one or two units to write
    typedef struct packed {
        unc_unit_t u1;
        unc_unit_t u0;
        logic      two;
    } unc_entry_t;

endpackage

[rtl/core/unc_front.sv]
// front end: accepts code units, tracks mark and held cr, classifies output
// depends on unc_pkg and utf16_newline_converter_assert.svh
module unc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  unc_pkg::unc_cfg_t   cfg,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // first_byte [7:0], second_byte [15:8]
    input  logic                s_tlast,   // final_unit
    input  logic                full,
    output logic                push,
    output unc_pkg::unc_entry_t entry
);
    import unc_pkg::*;

    logic       bom_seen_reg, bom_seen_next;
    logic       big_endian_reg, big_endian_next;
    logic       cr_pending_reg, cr_pending_next;
    logic       accept;
    logic [1:0] n;
    unc_unit_t  in_unit, r0, r1, nl_unit, cr_unit, lf_unit;
    logic       is_cr, is_lf;

    function automatic unc_unit_t make_code(input logic be, input logic [7:0] c);
        unc_unit_t u;
        if (be)
        begin
            u.first_byte  = 8'h00;
            u.second_byte = c;
        end
        else
        begin
            u.first_byte  = c;
            u.second_byte = 8'h00;
        end
        return u;
    endfunction

    function automatic unc_unit_t swap_unit(input logic sw, input unc_unit_t u);
        unc_unit_t r;
        r.first_byte  = sw ? u.second_byte : u.first_byte;
        r.second_byte = sw ? u.first_byte  : u.second_byte;
        return r;
    endfunction

    assign s_tready = !full;
    assign accept   = s_tvalid && !full;

    assign in_unit.first_byte  = s_tdata[7:0];
    assign in_unit.second_byte = s_tdata[15:8];
    assign cr_unit = make_code(big_endian_reg, CODE_CR);
    assign lf_unit = make_code(big_endian_reg, CODE_LF);
    assign nl_unit = (cfg.target_format == FMT_LF) ? lf_unit : cr_unit;
    assign is_cr   = (in_unit == cr_unit);
    assign is_lf   = (in_unit == lf_unit);

    always_comb
    begin
        n               = 2'd0;
        r0              = in_unit;
        r1              = in_unit;
        bom_seen_next   = bom_seen_reg;
        big_endian_next = big_endian_reg;
        cr_pending_next = cr_pending_reg;
        if (cfg.source_format == cfg.target_format)
        begin
            cr_pending_next = 1'b0;
            n               = 2'd1;
        end
        else if (cfg.source_format > FMT_CRLF)
        begin
            cr_pending_next = 1'b0;
        end
        else if (!bom_seen_reg)
        begin
            bom_seen_next   = 1'b1;
            big_endian_next = (in_unit.first_byte == BOM_HIGH) &&
                              (in_unit.second_byte == BOM_LOW);
            cr_pending_next = 1'b0;
            n               = 2'd1;
        end
        else
        begin
            case (cfg.source_format)
                FMT_LF:
                begin
                    cr_pending_next = 1'b0;
                    n               = 2'd1;
                    if (is_lf)
                    begin
                        r0 = cr_unit;
                        if (cfg.target_format != FMT_CR)
                        begin
                            r1 = lf_unit;
                            n  = 2'd2;
                        end
                    end
                end
                FMT_CR:
                begin
                    cr_pending_next = 1'b0;
                    n               = 2'd1;
                    if (is_cr)
                    begin
                        if (cfg.target_format == FMT_LF)
                        begin
                            r0 = lf_unit;
                        end
                        else
                        begin
                            r0 = cr_unit;
                            r1 = lf_unit;
                            n  = 2'd2;
                        end
                    end
                end
                default:
                begin
                    // cr-lf source: a cr waits for the next unit
                    if (cr_pending_reg)
                    begin
                        cr_pending_next = 1'b0;
                        n               = 2'd1;
                        if (is_lf)
                        begin
                            r0 = nl_unit;
                        end
                        else
                        begin
                            r0 = cr_unit;
                            if (is_cr)
                            begin
                                cr_pending_next = 1'b1;
                            end
                            else
                            begin
                                n = 2'd2;
                            end
                        end
                    end
                    else if (is_cr)
                    begin
                        cr_pending_next = 1'b1;
                    end
                    else
                    begin
                        n = 2'd1;
                    end
                    // end of stream flushes a held cr
                    if (s_tlast && cr_pending_next)
                    begin
                        cr_pending_next = 1'b0;
                        if (n == 2'd0)
                        begin
                            r0 = cr_unit;
                            n  = 2'd1;
                        end
                        else
                        begin
                            r1 = cr_unit;
                            n  = 2'd2;
                        end
                    end
                end
            endcase
        end
        if (s_tlast)
        begin
            bom_seen_next   = 1'b0;
            big_endian_next = 1'b0;
            cr_pending_next = 1'b0;
        end
    end

    assign push      = accept && (n != 2'd0);
    assign entry.u0  = swap_unit(cfg.swap_bytes, r0);
    assign entry.u1  = swap_unit(cfg.swap_bytes, r1);
    assign entry.two = (n == 2'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bom_seen_reg   <= 1'b0;
            big_endian_reg <= 1'b0;
            cr_pending_reg <= 1'b0;
        end
        else if (accept)
        begin
            bom_seen_reg   <= bom_seen_next;
            big_endian_reg <= big_endian_next;
            cr_pending_reg <= cr_pending_next;
        end
    end

`include "utf16_newline_converter_assert.svh"
    `UNC_ASSERT_SAME(a_cr_needs_mark, clk, rst_n, cr_pending_reg, bom_seen_reg)
    `UNC_ASSERT_SAME(a_endian_needs_mark, clk, rst_n, big_endian_reg, bom_seen_reg)
    `UNC_ASSERT_NEXT(a_last_rearms, clk, rst_n, accept && s_tlast,
        !bom_seen_reg && !cr_pending_reg)

endmodule

[rtl/core/unc_queue.sv]
// short queue of classified entries between front and back end
// depends on unc_pkg and utf16_newline_converter_assert.svh
module unc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  unc_pkg::unc_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output unc_pkg::unc_entry_t head
);
    import unc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    unc_entry_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

`include "utf16_newline_converter_assert.svh"
    `UNC_ASSERT_SAME(a_no_push_full, clk, rst_n, full, !push)
    `UNC_ASSERT_SAME(a_no_pop_empty, clk, rst_n, empty, !pop)
    `UNC_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH))

endmodule

[rtl/core/unc_back.sv]
// back end: writes the one or two units of each entry through an output register
// depends on unc_pkg and utf16_newline_converter_assert.svh
module unc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                empty,
    input  unc_pkg::unc_entry_t head,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // out_first_byte [7:0], out_second_byte [15:8]
    output logic                m_tlast    // run_end
);
    import unc_pkg::*;

    logic      out_valid_reg, out_valid_next;
    logic      phase_reg, phase_next;
    unc_unit_t out_unit_reg;
    logic      out_last_reg;
    logic      load;
    logic      last_unit;
    unc_unit_t sel_unit;

    assign load      = (!out_valid_reg || m_tready) && !empty;
    assign sel_unit  = phase_reg ? head.u1 : head.u0;
    assign last_unit = phase_reg || !head.two;
    assign pop       = load && last_unit;

    always_comb
    begin
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            phase_next     = !last_unit;
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_unit_reg <= sel_unit;
            out_last_reg <= last_unit;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_unit_reg.second_byte, out_unit_reg.first_byte};
    assign m_tlast  = out_last_reg;

`include "utf16_newline_converter_assert.svh"
    `UNC_ASSERT_SAME(a_phase_has_head, clk, rst_n, phase_reg, !empty && head.two)
    `UNC_ASSERT_NEXT(a_second_follows, clk, rst_n, load && !last_unit,
        out_valid_reg && !out_last_reg)

endmodule

[rtl/core/utf16_newline_converter.sv]
// top level of the utf16 newline converter: configuration registers and apb port
// depends on unc_pkg, unc_front, unc_queue, unc_back
//
//  channel   direction  handshake         payload
//  s_*       in         tvalid / tready   tdata = first_byte, second_byte; tlast = final_unit
//  m_*       out        tvalid / tready   tdata = out_first_byte, out_second_byte; tlast = run_end
//  apb       in         psel / penable    paddr, pwdata, prdata (source, target, swap)
//
// with m_tready high, units that yield one result run at one unit per cycle;
// a unit that yields two results holds the output register for both results in turn
// an input transaction reaches the output through the queue slot and then the output register
// the two-entry queue lets the front keep accepting while a result waits on m_tready
// reset clears the mark, endian and held-cr state and all configuration register values
// final_unit flushes a held cr and rearms mark detection for the next stream
module utf16_newline_converter (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // first_byte [7:0], second_byte [15:8]
    input  logic        s_tlast,    // final_unit
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // out_first_byte [7:0], out_second_byte [15:8]
    output logic        m_tlast,    // run_end
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import unc_pkg::*;

    unc_cfg_t   cfg_reg;
    unc_cfg_t   cfg_next;
    logic       cfg_write;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;
    unc_entry_t push_entry;
    unc_entry_t head;

    // register file: one word per register, word index in paddr[3:2]
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (paddr[3:2])
                REG_SOURCE: cfg_next.source_format = pwdata[1:0];
                REG_TARGET: cfg_next.target_format = pwdata[1:0];
                REG_SWAP:   cfg_next.swap_bytes    = pwdata[0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read back
    always_comb
    begin
        case (paddr[3:2])
            REG_SOURCE: prdata = 32'(cfg_reg.source_format);
            REG_TARGET: prdata = 32'(cfg_reg.target_format);
            REG_SWAP:   prdata = 32'(cfg_reg.swap_bytes);
            default:    prdata = 32'h0;
        endcase
    end

    // front end classifies each unit into zero, one or two results
    unc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .full     (full),
        .push     (push),
        .entry    (push_entry)
    );

    // decoupling queue
    unc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .empty      (empty),
        .head       (head)
    );

    // back end drives the output stream
    unc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
